FILE: sv/stack_with_search_defines.svh
// Assertion helpers used by the stack datapath.
`ifndef STACK_WITH_SEARCH_DEFINES_SVH
`define STACK_WITH_SEARCH_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define SWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle brings a consequence in the next.
`define SWS_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sws_pkg.sv
package sws_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;
  localparam int POS_W     = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED    = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_POPPED    = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_MATCH     = 3'd4,
    ST_NOTFOUND  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RESP,
    S_SCAN,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    push;
    logic    pop;
    logic    scan_start;
    logic    scan_step;
    logic    pend_set;
    logic    pend_clr;
    logic    out_load;
    status_t out_status;
    logic    out_last;
  } sws_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            hit;
    logic            more;
    logic            pend_valid;
    logic            out_free;
  } sws_stat_t;

endpackage

FILE: sv/stack_with_search.sv
// Push and pop: the result is loaded into the output register from the response state once
// that register is free, and the next operation can be taken when the controller is back in idle.
// Search over n held entries: one entry per cycle through the single memory read port,
// unless a held match must wait for a busy output.
// Reset (rst_n low, synchronous) empties the stack and drops any pending result;
// the entry storage itself is not cleared, and no clearing pass is needed.
module stack_with_search import sws_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_operation,
  input  logic signed [DATA_W-1:0] in_push_value,
  input  logic signed [DATA_W-1:0] in_search_key,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [POS_W-1:0]         out_position,
  output logic                     out_last
);

  // The controller sequences one operation at a time: it takes a transfer when idle,
  // decodes the operation against the fill level, and then either loads a single
  // response or walks the stack from the top. During a search the most recent match
  // is held back one step, since only the end of the scan tells whether it is the
  // final result; it goes out with last set, or a not-found result goes out instead.
  // The output register is separate, so a finished result may wait for its transfer
  // while the controller already returns to idle and takes the next operation.
  sws_cmd_t  cmd;
  sws_stat_t st;

  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the stack memory, fill count, scan index and output register.
  sws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_operation  (in_operation),
    .in_push_value (in_push_value),
    .in_search_key (in_search_key),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_data_out  (out_data_out),
    .out_position  (out_position),
    .out_last      (out_last)
  );

endmodule

FILE: sv/sws_ctrl.sv
module sws_ctrl import sws_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sws_stat_t st,
  output sws_cmd_t  cmd
);

  state_t  state_r, state_nxt;
  status_t resp_r, resp_nxt;
  logic    advance;

  // A scan step may proceed unless it must flush a held match into a busy output.
  assign advance = !(st.hit && st.pend_valid) || st.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resp_r  <= ST_PUSHED;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (st.op)
          OP_PUSH:   state_nxt = S_RESP;
          OP_POP:    state_nxt = S_RESP;
          OP_SEARCH: state_nxt = st.empty ? S_RESP : S_SCAN;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_RESP: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (advance && !st.more) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    resp_nxt = resp_r;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
      end
      S_DECODE: begin
        case (st.op)
          OP_PUSH: begin
            if (st.full) begin
              resp_nxt = ST_OVERFLOW;
            end else begin
              cmd.push = 1'b1;
              resp_nxt = ST_PUSHED;
            end
          end
          OP_POP: begin
            if (st.empty) begin
              resp_nxt = ST_UNDERFLOW;
            end else begin
              cmd.pop  = 1'b1;
              resp_nxt = ST_POPPED;
            end
          end
          OP_SEARCH: begin
            if (st.empty) resp_nxt = ST_NOTFOUND;
            else cmd.scan_start = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = resp_r;
          cmd.out_last   = 1'b1;
        end
      end
      S_SCAN: begin
        if (advance) begin
          cmd.pend_set  = st.hit;
          cmd.scan_step = st.more;
          if (st.hit && st.pend_valid) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = ST_MATCH;
            cmd.out_last   = 1'b0;
          end
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = st.pend_valid ? ST_MATCH : ST_NOTFOUND;
          cmd.out_last   = 1'b1;
          cmd.pend_clr   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/sws_dp.sv
`include "stack_with_search_defines.svh"

module sws_dp import sws_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sws_cmd_t                 cmd,
  output sws_stat_t                st,
  input  logic [OP_W-1:0]          in_operation,
  input  logic signed [DATA_W-1:0] in_push_value,
  input  logic signed [DATA_W-1:0] in_search_key,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [POS_W-1:0]         out_position,
  output logic                     out_last
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int ExtW  = (CntW > POS_W) ? CntW : POS_W;

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [CntW-1:0]  fill_r, fill_nxt;
  logic [AddrW-1:0] idx_r, idx_nxt;
  logic [CntW-1:0]  pos_r, pos_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [CntW-1:0]  pend_pos_r, pend_pos_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [OP_W-1:0]          op_r;
  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] rd_data_r;
  status_t                  out_status_r;
  logic signed [DATA_W-1:0] out_data_r;
  logic [POS_W-1:0]         out_pos_r;
  logic                     out_last_r;

  logic [AddrW-1:0] top_addr;
  logic [AddrW-1:0] rd_addr;
  logic             rd_en;
  logic             out_free;
  logic [ExtW-1:0]  pend_pos_ext;

  assign top_addr     = AddrW'(fill_r - CntW'(1));
  assign rd_addr      = cmd.scan_step ? (idx_r - AddrW'(1)) : top_addr;
  assign rd_en        = cmd.pop || cmd.scan_start || cmd.scan_step;
  assign out_free     = !out_valid_r || !out_stall;
  assign pend_pos_ext = ExtW'(pend_pos_r);

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.push) fill_nxt = fill_r + CntW'(1);
    else if (cmd.pop) fill_nxt = fill_r - CntW'(1);

    idx_nxt = idx_r;
    pos_nxt = pos_r;
    if (cmd.scan_start) begin
      idx_nxt = top_addr;
      pos_nxt = CntW'(1);
    end else if (cmd.scan_step) begin
      idx_nxt = idx_r - AddrW'(1);
      pos_nxt = pos_r + CntW'(1);
    end

    pend_valid_nxt = pend_valid_r;
    pend_pos_nxt   = pend_pos_r;
    if (cmd.pend_clr) begin
      pend_valid_nxt = 1'b0;
    end else if (cmd.pend_set) begin
      pend_valid_nxt = 1'b1;
      pend_pos_nxt   = pos_r;
    end

    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      idx_r        <= '0;
      pos_r        <= '0;
      pend_valid_r <= 1'b0;
      pend_pos_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      idx_r        <= idx_nxt;
      pos_r        <= pos_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_pos_r   <= pend_pos_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_operation;
      val_r <= in_push_value;
      key_r <= in_search_key;
    end
  end

  // Stack storage with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.push) mem[AddrW'(fill_r)] <= val_r;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
      case (cmd.out_status)
        ST_POPPED: begin
          out_data_r <= rd_data_r;
          out_pos_r  <= '0;
        end
        ST_MATCH: begin
          out_data_r <= key_r;
          out_pos_r  <= pend_pos_ext[POS_W-1:0];
        end
        default: begin
          out_data_r <= '0;
          out_pos_r  <= '0;
        end
      endcase
    end
  end

  assign st.op         = op_r;
  assign st.full       = (fill_r == CntW'(DEPTH));
  assign st.empty      = (fill_r == '0);
  assign st.hit        = (rd_data_r == key_r);
  assign st.more       = (idx_r != '0);
  assign st.pend_valid = pend_valid_r;
  assign st.out_free   = out_free;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_out = out_data_r;
  assign out_position = out_pos_r;
  assign out_last     = out_last_r;

  `SWS_ASSERT(a_fill_bound, fill_r <= CntW'(DEPTH), "fill count beyond stack depth")
  `SWS_ASSERT(a_load_free, cmd.out_load |-> out_free, "result loaded over an untaken result")
  `SWS_ASSERT(a_push_room, cmd.push |-> !st.full, "push issued on a full stack")
  `SWS_ASSERT_NEXT(a_pop_dec, cmd.pop, fill_r == $past(fill_r) - CntW'(1),
    "pop did not lower the fill count")

endmodule

FILE: verif/tb_top.sv
`default_nettype none

// Testbench for the bounded LIFO stack with key search.
//
// An initial block fills a queue with pending operations: a short directed
// sequence first, then random operations shaped into fill and drain phases so
// that the stack regularly runs full and empty. A clocked driver offers one
// operation at a time on the input channel. At every accepted transfer it runs
// the operation through a behavioral copy of the stack and appends the results
// that the block must produce to a queue. A clocked monitor takes every result
// transfer and compares it field by field against the oldest queued result.
module tb_top;
  import sws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = DEPTH_DEF;
  // Operation code 3 has no meaning; the block drops it without a result.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_OPS     = 190;
  localparam int MAX_WAIT       = 5;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] key;
    bit                       drain;  // Hold off until every result is back.
  } stack_op_t;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         pos;
    logic                     last;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_operation = '0;
  logic signed [DATA_W-1:0] in_push_value = '0;
  logic signed [DATA_W-1:0] in_search_key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic signed [DATA_W-1:0] out_data_out;
  logic [POS_W-1:0] out_position;
  logic out_last;

  stack_op_t     pending_ops[$];
  stack_result_t expected_results[$];

  // Behavioral copy of the stack contents.
  logic signed [DATA_W-1:0] stack_words[STACK_DEPTH];
  int unsigned words_held = 0;

  int mismatch_count = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  stack_with_search #(.DEPTH(STACK_DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_push_value(in_push_value),
    .in_search_key(in_search_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_data_out (out_data_out),
    .out_position (out_position),
    .out_last     (out_last)
  );

  always #1 clk = ~clk;

  function automatic void queue_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] value,
                                   logic [DATA_W-1:0] key, bit drain);
    stack_op_t item;
    item.op = op;
    item.value = value;
    item.key = key;
    item.drain = drain;
    pending_ops.push_back(item);
  endfunction

  // Most words come from a small pool so that searches find repeated keys and
  // the extremes show up often; the rest are fully random.
  function automatic logic [DATA_W-1:0] pick_word();
    logic [DATA_W-1:0] pool[8];
    pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
             32'h0000_0001, 32'h55AA_55AA, 32'hAAAA_AAAA, 32'h0001_0000};
    if ($urandom_range(0, 3) != 0) begin
      return pool[$urandom_range(0, 7)];
    end
    return $urandom;
  endfunction

  // A wait drawn for one transfer; zero throughout a quiet stretch.
  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void expect_result(status_t status, logic [DATA_W-1:0] data,
                                        logic [POS_W-1:0] pos, logic last);
    stack_result_t res;
    res.status = status;
    res.data = data;
    res.pos = pos;
    res.last = last;
    expected_results.push_back(res);
  endfunction

  // Applies one accepted operation to the behavioral stack and queues the
  // results it must produce. A search reports matches from the top down.
  function automatic void apply_operation(stack_op_t item);
    int hits;
    int tail;
    hits = 0;
    case (item.op)
      OP_PUSH: begin
        if (words_held == STACK_DEPTH) begin
          expect_result(ST_OVERFLOW, '0, '0, 1'b1);
        end else begin
          stack_words[words_held] = item.value;
          words_held++;
          expect_result(ST_PUSHED, '0, '0, 1'b1);
        end
      end
      OP_POP: begin
        if (words_held == 0) begin
          expect_result(ST_UNDERFLOW, '0, '0, 1'b1);
        end else begin
          words_held--;
          expect_result(ST_POPPED, stack_words[words_held], '0, 1'b1);
        end
      end
      OP_SEARCH: begin
        for (int i = words_held; i > 0; i--) begin
          if (stack_words[i-1] == item.key) begin
            expect_result(ST_MATCH, item.key, POS_W'(words_held - i + 1), 1'b0);
            hits++;
          end
        end
        if (hits == 0) begin
          expect_result(ST_NOTFOUND, '0, '0, 1'b1);
        end else begin
          tail = expected_results.size() - 1;
          expected_results[tail].last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void flag_mismatch(string what, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch in result %0d, %s: expected %0h, got %0h",
               results_seen, what, want, got);
    end
  endfunction

  // Driver. Each operation is held on the input ports until its transfer. The
  // wait before the next one is drawn when an operation is put on the ports, and
  // an operation marked for draining is held back until every queued result has
  // come out of the block. valid gets exactly one assignment per edge.
  always @(posedge clk) begin
    int send_wait;
    bit send_quiet;
    bit offering;
    stack_op_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = draw_wait(1'b0);
      send_quiet = 1'b0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        apply_operation(item);
        offering = 1'b0;
      end
      if (!offering && pending_ops.size() != 0) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (!pending_ops[0].drain || expected_results.size() == 0) begin
          item = pending_ops.pop_front();
          in_operation <= item.op;
          in_push_value <= item.value;
          in_search_key <= item.key;
          offering = 1'b1;
          // Now and then switch between idling and back-to-back transfers.
          if ($urandom_range(0, 15) == 0) begin
            send_quiet = !send_quiet;
          end
          send_wait = draw_wait(send_quiet);
        end
      end
      in_valid <= offering;
    end
  end

  // Monitor. After each result transfer the receiver draws how many cycles to
  // stall the next result; the count runs down only while a result is offered,
  // so the stall lands on the result itself.
  always @(posedge clk) begin
    int hold_left;
    bit recv_quiet;
    stack_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      recv_quiet = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          flag_mismatch("nothing expected, status", '0, DATA_W'(out_status));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            flag_mismatch("status", DATA_W'(want.status), DATA_W'(out_status));
          end
          if (out_data_out !== want.data) begin
            flag_mismatch("data_out", want.data, out_data_out);
          end
          if (out_position !== want.pos) begin
            flag_mismatch("position", DATA_W'(want.pos), DATA_W'(out_position));
          end
          if (out_last !== want.last) begin
            flag_mismatch("last", DATA_W'(want.last), DATA_W'(out_last));
          end
        end
        if ($urandom_range(0, 15) == 0) begin
          recv_quiet = !recv_quiet;
        end
        hold_left = draw_wait(recv_quiet);
      end else if (out_valid && hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0);
    end
  end

  // Watchdog: a long run of cycles with no transfer on either channel means
  // the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int counted;
    int fill_guess;
    int roll;
    bit filling;
    logic [OP_W-1:0] op;

    // Directed part. The stack starts empty: pop and search must report
    // underflow and not found, and the meaningless code is dropped.
    queue_op(OP_POP, pick_word(), pick_word(), 1'b0);
    queue_op(OP_SEARCH, pick_word(), 32'sd5, 1'b0);
    queue_op(OP_UNUSED, pick_word(), pick_word(), 1'b0);
    // Extremes of the word range, then a hit below the top and a miss.
    queue_op(OP_PUSH, 32'h8000_0000, pick_word(), 1'b0);
    queue_op(OP_PUSH, 32'h7FFF_FFFF, pick_word(), 1'b0);
    queue_op(OP_PUSH, 32'h0000_0000, pick_word(), 1'b0);
    queue_op(OP_PUSH, 32'hFFFF_FFFF, pick_word(), 1'b0);
    queue_op(OP_SEARCH, pick_word(), 32'h7FFF_FFFF, 1'b0);
    queue_op(OP_SEARCH, pick_word(), 32'sd123, 1'b0);
    queue_op(OP_POP, pick_word(), pick_word(), 1'b0);
    // Fill the stack with copies of the most negative word, push once more
    // into the full stack, then search for that word: fourteen matches, the
    // deepest one at the bottom position.
    for (int i = 0; i < STACK_DEPTH - 3; i++) begin
      queue_op(OP_PUSH, 32'h8000_0000, pick_word(), 1'b0);
    end
    queue_op(OP_PUSH, 32'h7FFF_FFFF, pick_word(), 1'b0);
    queue_op(OP_SEARCH, pick_word(), 32'h8000_0000, 1'b0);

    // Random part, alternating between filling and draining phases. A phase
    // turns only once the stack reaches its bound, and then at random, so overflow and
    // underflow keep occurring. Operations queued at the start and halfway wait for the block to drain.
    counted = 0;
    fill_guess = STACK_DEPTH;
    filling = 1'b0;
    while (counted < RANDOM_OPS) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        op = OP_UNUSED;
      end else if (roll < 25) begin
        op = OP_SEARCH;
      end else if (roll < 85) begin
        op = filling ? OP_PUSH : OP_POP;
      end else begin
        op = filling ? OP_POP : OP_PUSH;
      end
      if (op == OP_PUSH && fill_guess < STACK_DEPTH) begin
        fill_guess++;
      end
      if (op == OP_POP && fill_guess > 0) begin
        fill_guess--;
      end
      if ((filling && fill_guess == STACK_DEPTH) || (!filling && fill_guess == 0)) begin
        if ($urandom_range(0, 2) == 0) begin
          filling = !filling;
        end
      end
      queue_op(op, pick_word(), pick_word(), counted == 0 || counted == RANDOM_OPS / 2);
      if (op != OP_UNUSED) begin
        counted++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    // Give a stray late result the chance to show up.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+sv
sv/sws_pkg.sv
sv/sws_ctrl.sv
sv/sws_dp.sv
sv/stack_with_search.sv
verif/tb_top.sv
